// ===== sv/bpsc_pkg.sv =====
// ----------------------------------------------------------------------------
// bpsc_pkg
// Shared types and constants for the button press sequence classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package bpsc_pkg;

  // Field widths
  localparam int unsigned TYPE_W  = 16;
  localparam int unsigned CODE_W  = 16;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // Default depth of the press store
  localparam int unsigned MAX_PRESSES_DEF = 8;

  // Item kinds
  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_EVENT = 1'b1;

  // Event decode
  localparam logic [TYPE_W-1:0]  KEY_EVENT_TYPE   = 16'h0001;
  localparam logic [CODE_W-1:0]  MISC_BUTTON_CODE = 16'h0100;
  localparam logic [VALUE_W-1:0] VALUE_RELEASED   = 32'd0;
  localparam logic [VALUE_W-1:0] VALUE_PRESSED    = 32'd1;

  // Register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_US = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 2'd1;
  localparam logic [TIME_W-1:0]    LONG_PRESS_RESET  = 32'd1000000;
  localparam logic [TIME_W-1:0]    TIMEOUT_RESET     = 32'd100;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SHOW
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic take_item;
    logic emit_start;
    logic emit_next;
    logic emit_done;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic emit_req;
    logic last;
  } status_t;

endpackage

`default_nettype wire

// ===== sv/bpsc_ctrl.sv =====
// ----------------------------------------------------------------------------
// bpsc_ctrl
// Sequencer: takes items while idle and walks the stored sequence out.
// ----------------------------------------------------------------------------
`default_nettype none

module bpsc_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  input  wire bpsc_pkg::status_t status_i,
  output bpsc_pkg::cmd_t         cmd_o
);
  import bpsc_pkg::*;

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.take_item = in_valid_i;
        if (in_valid_i && status_i.emit_req) begin
          cmd_o.emit_start = 1'b1;
          state_d          = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_d = ST_SHOW;
      end
      ST_SHOW: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (status_i.last) begin
            cmd_o.emit_done = 1'b1;
            state_d         = ST_IDLE;
          end else begin
            cmd_o.emit_next = 1'b1;
            state_d         = ST_LOAD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/bpsc_dp.sv =====
// ----------------------------------------------------------------------------
// bpsc_dp
// Datapath: config registers, press timing, press store and idle counter.
// ----------------------------------------------------------------------------
`default_nettype none

module bpsc_dp #(
  parameter int unsigned MAX_PRESSES = bpsc_pkg::MAX_PRESSES_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [bpsc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [bpsc_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  wire logic                                 func_i,
  input  wire logic [bpsc_pkg::TYPE_W-1:0]          ev_type_i,
  input  wire logic [bpsc_pkg::CODE_W-1:0]          ev_code_i,
  input  wire logic [bpsc_pkg::VALUE_W-1:0]         ev_value_i,
  input  wire logic [bpsc_pkg::TIME_W-1:0]          time_us_i,
  input  wire bpsc_pkg::cmd_t                       cmd_i,
  output bpsc_pkg::status_t                         status_o,
  output logic                                      press_kind_o
);
  import bpsc_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_PRESSES + 1);
  localparam int unsigned IDX_W = (MAX_PRESSES > 1) ? $clog2(MAX_PRESSES) : 1;

  logic [TIME_W-1:0] long_press_q;
  logic [TIME_W-1:0] timeout_q;
  logic              button_down_q;
  logic [TIME_W-1:0] press_stamp_q;
  logic [TIME_W-1:0] idle_count_q;
  logic [CNT_W-1:0]  press_count_q;
  logic [IDX_W-1:0]  emit_idx_q;
  logic              mem_q [MAX_PRESSES];
  logic              rd_q;

  logic              key_match;
  logic              is_press;
  logic              is_release;
  logic              seq_empty;
  logic              has_room;
  logic [TIME_W-1:0] idle_inc;
  logic              fire;
  logic [TIME_W-1:0] held;
  logic              held_long;
  logic              store_we;

  // Decode the item
  always_comb begin
    key_match  = (func_i == FUNC_EVENT) && (ev_type_i == KEY_EVENT_TYPE) &&
                 (ev_code_i == MISC_BUTTON_CODE);
    is_press   = key_match && (ev_value_i == VALUE_PRESSED);
    is_release = key_match && (ev_value_i == VALUE_RELEASED);
    seq_empty  = (press_count_q == '0);
    has_room   = (press_count_q < CNT_W'(MAX_PRESSES));
    // advance the timeout only while the button is up with presses stored
    idle_inc   = idle_count_q + {{(TIME_W-1){1'b0}}, (!button_down_q && !seq_empty)};
    fire       = (idle_inc > timeout_q);
    held       = time_us_i - press_stamp_q;
    held_long  = (held > long_press_q);
    store_we   = cmd_i.take_item && is_release && has_room;
  end

  assign status_o.emit_req = (func_i == FUNC_TICK) && fire && !seq_empty;
  assign status_o.last     = ((CNT_W'(emit_idx_q) + CNT_W'(1)) == press_count_q);
  assign press_kind_o      = rd_q;

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_press_q <= LONG_PRESS_RESET;
      timeout_q    <= TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_LONG_PRESS_US) begin
        long_press_q <= cfg_data_i;
      end else if (cfg_index_i == CFG_TIMEOUT_TICKS) begin
        timeout_q <= cfg_data_i;
      end
    end
  end

  // Button state, idle counter, fill count and read pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      button_down_q <= 1'b0;
      press_stamp_q <= '0;
      idle_count_q  <= '0;
      press_count_q <= '0;
      emit_idx_q    <= '0;
    end else begin
      if (cmd_i.take_item) begin
        if (func_i == FUNC_TICK) begin
          idle_count_q <= fire ? '0 : idle_inc;
        end else if (is_press) begin
          button_down_q <= 1'b1;
          press_stamp_q <= time_us_i;
        end else if (is_release) begin
          button_down_q <= 1'b0;
          if (has_room) begin
            press_count_q <= press_count_q + CNT_W'(1);
          end
        end
      end
      if (cmd_i.emit_start) begin
        emit_idx_q <= '0;
      end else if (cmd_i.emit_next) begin
        emit_idx_q <= emit_idx_q + IDX_W'(1);
      end
      if (cmd_i.emit_done) begin
        press_count_q <= '0;
      end
    end
  end

  // Press store: append on release while there is room, read at the emission pointer
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      mem_q[press_count_q[IDX_W-1:0]] <= held_long;
    end
    rd_q <= mem_q[emit_idx_q];
  end

endmodule

`default_nettype wire

// ===== sv/button_press_sequence_classifier_unit.sv =====
// Events and ticks are taken only while idle; ready drops only while a sequence is emitted.
// A tick that times out a sequence of presses starts the emission; each result then passes
// the load state (store read) and the show state, where it is held until out_ready is high.
// The load state per result is set by the registered read port of the press store.
// Reset clears config to defaults, the button to up, the counter and the fill count;
// the press store contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// button_press_sequence_classifier_unit
// Classifies button presses as short or long and emits the sequence after
// a timeout of idle ticks.
// ----------------------------------------------------------------------------
`default_nettype none

module button_press_sequence_classifier_unit #(
  parameter int unsigned MAX_PRESSES = bpsc_pkg::MAX_PRESSES_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [bpsc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [bpsc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic                            func_i,
  input  wire logic [bpsc_pkg::TYPE_W-1:0]     ev_type_i,
  input  wire logic [bpsc_pkg::CODE_W-1:0]     ev_code_i,
  input  wire logic [bpsc_pkg::VALUE_W-1:0]    ev_value_i,
  input  wire logic [bpsc_pkg::TIME_W-1:0]     time_us_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic                                 press_kind_o,
  output logic                                 last_press_o
);
  import bpsc_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Config writes are always taken
  assign cfg_ready_o  = 1'b1;
  assign last_press_o = status.last;

  bpsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  bpsc_dp #(
    .MAX_PRESSES (MAX_PRESSES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .func_i       (func_i),
    .ev_type_i    (ev_type_i),
    .ev_code_i    (ev_code_i),
    .ev_value_i   (ev_value_i),
    .time_us_i    (time_us_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .press_kind_o (press_kind_o)
  );

endmodule

`default_nettype wire

// ===== sv/bpsc_checker.sv =====
// ----------------------------------------------------------------------------
// bpsc_checker
// Port-level checks on item flow and sequence emission.
// ----------------------------------------------------------------------------
`default_nettype none

module bpsc_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_o,
  input wire logic func_i,
  input wire logic out_valid_o,
  input wire logic out_ready_i,
  input wire logic press_kind_o,
  input wire logic last_press_o
);
  import bpsc_pkg::*;

  // No item is taken while a beat is on offer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("item taken during emission");

  // An event never starts an emission
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && func_i == FUNC_EVENT) |=> !out_valid_o)
    else $error("event caused a result");

  // Mid-sequence beat keeps the input closed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_press_o) |=> !in_ready_o)
    else $error("sequence cut short");

  // Last beat hands control back to the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_press_o) |=> (in_ready_o && !out_valid_o))
    else $error("emission did not end after last beat");

  // Stalled beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(press_kind_o) && $stable(last_press_o)))
    else $error("stalled beat changed");

endmodule

bind button_press_sequence_classifier_unit bpsc_checker u_bpsc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .func_i       (func_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .press_kind_o (press_kind_o),
  .last_press_o (last_press_o)
);

`default_nettype wire
